@@ rtl/keyboard_backlight_controller_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Keyboard backlight controller assertion macros
// Concurrent assertion helpers; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef KEYBOARD_BACKLIGHT_CONTROLLER_UNIT_ASSERT_SVH
`define KEYBOARD_BACKLIGHT_CONTROLLER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define KBLC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("kblc assertion failed");
`define KBLC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("kblc assertion failed");
`else
`define KBLC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define KBLC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ rtl/kblc_pkg.sv @@
// ----------------------------------------------------------------------------
// Keyboard backlight controller package
// Widths, op codes, command constants, color tables and shared helpers.
// ----------------------------------------------------------------------------
package kblc_pkg;

  localparam int unsigned OpW       = 4;
  localparam int unsigned ValueW    = 8;
  localparam int unsigned BrightW   = 8;
  localparam int unsigned ThemeW    = 5;
  localparam int unsigned CmdW      = 32;
  localparam int unsigned IdxW      = 3;
  localparam int unsigned NumThemes = 22;
  localparam int unsigned NumLevels = 6;

  localparam logic [OpW-1:0] OP_SET_BRIGHT = 4'd0;
  localparam logic [OpW-1:0] OP_TOGGLE     = 4'd1;
  localparam logic [OpW-1:0] OP_STEP_DOWN  = 4'd2;
  localparam logic [OpW-1:0] OP_STEP_UP    = 4'd3;
  localparam logic [OpW-1:0] OP_SET_THEME  = 4'd4;
  localparam logic [OpW-1:0] OP_NEXT_THEME = 4'd5;
  localparam logic [OpW-1:0] OP_RESUME     = 4'd6;
  localparam logic [OpW-1:0] OP_ENABLE     = 4'd7;
  localparam logic [OpW-1:0] OP_DISABLE    = 4'd8;

  localparam logic [CmdW-1:0] CmdBright  = 32'hF400_0000;
  localparam logic [CmdW-1:0] CmdEnable  = 32'hE007_F001;
  localparam logic [CmdW-1:0] CmdDisable = 32'hE000_3001;

  localparam logic [BrightW-1:0] ToggleReset   = 8'd72;
  localparam logic [ThemeW-1:0]  ThemeFallback = 5'd5;
  localparam logic [ThemeW-1:0]  ThemeLast     = 5'd21;

  localparam logic [BrightW-1:0] StepLevels [NumLevels] = '{
    8'd48, 8'd72, 8'd96, 8'd144, 8'd192, 8'd255
  };

  localparam logic [CmdW-1:0] RegionBase [4] = '{
    32'hF000_0000, 32'hF100_0000, 32'hF200_0000, 32'hF300_0000
  };

  // Colors are stored as 0xRRGGBB.
  localparam logic [23:0] RomColour [4][NumThemes] = '{
    '{24'h0000FF, 24'hFF0000, 24'h0000FF, 24'hFFFFFF, 24'hFF00FF, 24'hFF6700,
      24'h2000FF, 24'h00FF00, 24'h00FFFF, 24'hBBE30A, 24'h15F4EE, 24'h0000FF,
      24'hFF0000, 24'hFF0020, 24'hFF6700, 24'h00FF00, 24'hFF6700, 24'h0000FF,
      24'h0000FF, 24'hFF00FF, 24'hFF0000, 24'hFFFF00},
    '{24'h00FF00, 24'hFF0000, 24'h0000FF, 24'hFFFFFF, 24'hFF00FF, 24'hFF6700,
      24'h2000FF, 24'h00FF00, 24'h00FFFF, 24'hBBE30A, 24'h15F4EE, 24'hFF0000,
      24'h00FF00, 24'hFFFF00, 24'h000000, 24'h0000FF, 24'hFFFFFF, 24'hFF00FF,
      24'hFFFFFF, 24'hFFFF00, 24'hFF6700, 24'hFFFF00},
    '{24'h0000FF, 24'hFF0000, 24'h0000FF, 24'hFFFFFF, 24'hFF00FF, 24'hFF6700,
      24'h2000FF, 24'h00FF00, 24'h00FFFF, 24'hBBE30A, 24'h15F4EE, 24'hFFFFFF,
      24'h0000FF, 24'hFF0020, 24'hFF6700, 24'hFF00FF, 24'hFF6700, 24'hFFFF00,
      24'hFF6700, 24'h00FFFF, 24'hFF0020, 24'hFFFF00},
    '{24'h00FF00, 24'hFF0000, 24'h0000FF, 24'hFFFFFF, 24'hFF00FF, 24'hFF6700,
      24'h2000FF, 24'h00FF00, 24'h00FFFF, 24'hBBE30A, 24'h15F4EE, 24'hFF0000,
      24'hFF00FF, 24'hFFFF00, 24'h000000, 24'hFFFF00, 24'hFFFFFF, 24'h00FFFF,
      24'h0000FF, 24'hFFFFFF, 24'hFF6700, 24'hFFFF00}
  };

  typedef enum logic [2:0] {
    KIND_BRIGHT,
    KIND_ENABLE,
    KIND_DISABLE,
    KIND_THEME,
    KIND_RESUME
  } kind_e;

  // One event's worth of command words, with the state they report.
  typedef struct packed {
    kind_e              kind;
    logic [BrightW-1:0] brightness;
    logic [ThemeW-1:0]  theme;
  } job_t;

  function automatic logic [CmdW-1:0] region_word(logic [1:0] region,
                                                  logic [ThemeW-1:0] theme);
    logic [23:0] c;
    c = RomColour[region][theme];
    // Controller order is blue, red, green.
    return RegionBase[region] | {8'h00, c[7:0], c[23:16], c[15:8]};
  endfunction

  function automatic logic [IdxW-1:0] job_last_idx(kind_e kind);
    logic [IdxW-1:0] r;
    case (kind)
      KIND_THEME:  r = 3'd3;
      KIND_RESUME: r = 3'd6;
      default:     r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/kblc_in_if.sv @@
// ----------------------------------------------------------------------------
// Keyboard backlight event channel
// Valid/ready channel carrying one hotkey or host event per item.
// ----------------------------------------------------------------------------
interface kblc_in_if;
  logic                        valid;
  logic                        ready;
  logic [kblc_pkg::OpW-1:0]    op;
  logic [kblc_pkg::ValueW-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink (input valid, input op, input value, output ready);
endinterface

@@ rtl/kblc_out_if.sv @@
// ----------------------------------------------------------------------------
// Keyboard backlight command channel
// Valid/ready channel carrying one controller command word per item.
// ----------------------------------------------------------------------------
interface kblc_out_if;
  logic                         valid;
  logic                         ready;
  logic [kblc_pkg::CmdW-1:0]    command;
  logic                         last_command;
  logic [kblc_pkg::BrightW-1:0] brightness_now;
  logic [kblc_pkg::ThemeW-1:0]  theme_now;

  modport source (output valid, output command, output last_command,
                  output brightness_now, output theme_now, input ready);
  modport sink (input valid, input command, input last_command,
                input brightness_now, input theme_now, output ready);
endinterface

@@ rtl/kblc_state.sv @@
// ----------------------------------------------------------------------------
// Keyboard backlight state and event decode
// Holds brightness, toggle level and theme; turns an event into a job.
// ----------------------------------------------------------------------------
module kblc_state (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  logic [kblc_pkg::OpW-1:0]    op_i,
  input  logic [kblc_pkg::ValueW-1:0] value_i,
  output kblc_pkg::job_t              job_o,
  output logic                        has_words_o
);

  logic [kblc_pkg::BrightW-1:0] bright_q, bright_d;
  logic [kblc_pkg::BrightW-1:0] toggle_q, toggle_d;
  logic [kblc_pkg::ThemeW-1:0]  theme_q, theme_d;
  logic [kblc_pkg::BrightW-1:0] tog_bright, tog_level;
  logic [kblc_pkg::BrightW-1:0] dn_level, up_level;
  logic                         dn_found, up_found, bright_zero;
  kblc_pkg::kind_e              kind;

  assign bright_zero = (bright_q == '0);
  assign tog_bright  = bright_zero ? toggle_q : '0;
  assign tog_level   = bright_zero ? toggle_q : bright_q;

  // Levels ascend, so the last hit below is the nearest one down and the
  // last hit scanning downward is the nearest one up.
  always_comb begin
    dn_found = 1'b0;
    dn_level = '0;
    up_found = 1'b0;
    up_level = '0;
    for (int i = 0; i < kblc_pkg::NumLevels; i++) begin
      if (kblc_pkg::StepLevels[i] < bright_q) begin
        dn_found = 1'b1;
        dn_level = kblc_pkg::StepLevels[i];
      end
    end
    for (int i = kblc_pkg::NumLevels - 1; i >= 0; i--) begin
      if (kblc_pkg::StepLevels[i] > bright_q) begin
        up_found = 1'b1;
        up_level = kblc_pkg::StepLevels[i];
      end
    end
  end

  always_comb begin
    bright_d    = bright_q;
    toggle_d    = toggle_q;
    theme_d     = theme_q;
    kind        = kblc_pkg::KIND_BRIGHT;
    has_words_o = 1'b0;
    unique case (op_i)
      kblc_pkg::OP_SET_BRIGHT: begin
        bright_d    = value_i;
        has_words_o = 1'b1;
      end
      kblc_pkg::OP_TOGGLE: begin
        bright_d    = tog_bright;
        toggle_d    = tog_level;
        has_words_o = 1'b1;
      end
      kblc_pkg::OP_STEP_DOWN: begin
        if (bright_zero) begin
          bright_d    = tog_bright;
          toggle_d    = tog_level;
          has_words_o = 1'b1;
        end else if (dn_found) begin
          bright_d    = dn_level;
          has_words_o = 1'b1;
        end
      end
      kblc_pkg::OP_STEP_UP: begin
        if (bright_zero) begin
          bright_d    = tog_bright;
          toggle_d    = tog_level;
          has_words_o = 1'b1;
        end else if (up_found) begin
          bright_d    = up_level;
          has_words_o = 1'b1;
        end
      end
      kblc_pkg::OP_SET_THEME: begin
        theme_d     = (value_i >= kblc_pkg::ValueW'(kblc_pkg::NumThemes)) ?
                      kblc_pkg::ThemeFallback : value_i[kblc_pkg::ThemeW-1:0];
        kind        = kblc_pkg::KIND_THEME;
        has_words_o = 1'b1;
      end
      kblc_pkg::OP_NEXT_THEME: begin
        theme_d     = (theme_q >= kblc_pkg::ThemeLast) ? '0 : theme_q + 5'd1;
        kind        = kblc_pkg::KIND_THEME;
        has_words_o = 1'b1;
      end
      kblc_pkg::OP_RESUME: begin
        kind        = kblc_pkg::KIND_RESUME;
        has_words_o = 1'b1;
      end
      kblc_pkg::OP_ENABLE: begin
        kind        = kblc_pkg::KIND_ENABLE;
        has_words_o = 1'b1;
      end
      kblc_pkg::OP_DISABLE: begin
        kind        = kblc_pkg::KIND_DISABLE;
        has_words_o = 1'b1;
      end
      default: begin
        has_words_o = 1'b0;
      end
    endcase
  end

  // Every word of an event reports the state as it stands after the event.
  assign job_o.kind       = kind;
  assign job_o.brightness = bright_d;
  assign job_o.theme      = theme_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q <= '0;
      toggle_q <= kblc_pkg::ToggleReset;
      theme_q  <= '0;
    end else if (fire_i) begin
      bright_q <= bright_d;
      toggle_q <= toggle_d;
      theme_q  <= theme_d;
    end
  end

endmodule

@@ rtl/kblc_emit.sv @@
// ----------------------------------------------------------------------------
// Keyboard backlight command emitter
// Walks the words of the current job into a registered output stage.
// ----------------------------------------------------------------------------
`include "keyboard_backlight_controller_unit_assert.svh"

module kblc_emit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  kblc_pkg::job_t   job_i,
  output logic             job_free_o,
  kblc_out_if.source       out_o
);

  logic                       job_valid_q;
  kblc_pkg::job_t             job_q;
  logic [kblc_pkg::IdxW-1:0]  idx_q;
  logic [kblc_pkg::IdxW-1:0]  last_idx;
  logic                       job_last, word_move;
  logic [1:0]                 resume_region;
  logic [kblc_pkg::CmdW-1:0]  word;

  logic                         out_valid_q;
  logic [kblc_pkg::CmdW-1:0]    cmd_q;
  logic                         last_q;
  logic [kblc_pkg::BrightW-1:0] bright_q;
  logic [kblc_pkg::ThemeW-1:0]  theme_q;

  assign last_idx   = kblc_pkg::job_last_idx(job_q.kind);
  assign job_last   = (idx_q == last_idx);
  assign word_move  = job_valid_q && (!out_valid_q || out_o.ready);
  assign job_free_o = !job_valid_q || (word_move && job_last);

  // Resume sends its four region words at positions two to five.
  assign resume_region = idx_q[1:0] - 2'd2;

  always_comb begin
    unique case (job_q.kind)
      kblc_pkg::KIND_BRIGHT:  word = kblc_pkg::CmdBright | 32'(job_q.brightness);
      kblc_pkg::KIND_ENABLE:  word = kblc_pkg::CmdEnable;
      kblc_pkg::KIND_DISABLE: word = kblc_pkg::CmdDisable;
      kblc_pkg::KIND_THEME:   word = kblc_pkg::region_word(idx_q[1:0], job_q.theme);
      kblc_pkg::KIND_RESUME: begin
        if (idx_q == 3'd0) begin
          word = kblc_pkg::CmdDisable;
        end else if (idx_q == 3'd1) begin
          word = kblc_pkg::CmdBright | 32'(job_q.brightness);
        end else if (idx_q == last_idx) begin
          word = kblc_pkg::CmdEnable;
        end else begin
          word = kblc_pkg::region_word(resume_region, job_q.theme);
        end
      end
      default: word = kblc_pkg::CmdEnable;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (load_i) begin
      job_valid_q <= 1'b1;
      idx_q       <= '0;
    end else if (word_move && job_last) begin
      job_valid_q <= 1'b0;
    end else if (word_move) begin
      idx_q <= idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      job_q <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (word_move) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (word_move) begin
      cmd_q    <= word;
      last_q   <= job_last;
      bright_q <= job_q.brightness;
      theme_q  <= job_q.theme;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.command        = cmd_q;
  assign out_o.last_command   = last_q;
  assign out_o.brightness_now = bright_q;
  assign out_o.theme_now      = theme_q;

  `KBLC_ASSERT_IMP(a_idx_in_job, clk_i, rst_ni, job_valid_q, idx_q <= last_idx)
  `KBLC_ASSERT_IMP(a_load_when_free, clk_i, rst_ni, load_i, job_free_o)
  `KBLC_ASSERT_NXT(a_job_ends, clk_i, rst_ni, word_move && job_last && !load_i, !job_valid_q)
  `KBLC_ASSERT_NXT(a_load_starts, clk_i, rst_ni, load_i, job_valid_q && idx_q == 3'd0)

endmodule

@@ rtl/keyboard_backlight_controller_unit.sv @@
// ----------------------------------------------------------------------------
// Keyboard backlight controller
// Turns hotkey and host events into keyboard LED controller command words.
// ----------------------------------------------------------------------------
// The first command word of an event passes the event register, the emitter's
// job register and its output register. Throughput: one command word per cycle
// while the output is ready; an event has one to seven words, and an event with
// no words passes the event register without loading the emitter.
// Reset: brightness 0, toggle level 72, theme 0; no clearing pass.
module keyboard_backlight_controller_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  kblc_in_if.sink    in_i,
  kblc_out_if.source out_o
);

  logic                        ev_valid_q;
  logic [kblc_pkg::OpW-1:0]    ev_op_q;
  logic [kblc_pkg::ValueW-1:0] ev_value_q;
  logic                        ev_take;
  logic                        job_free;
  logic                        has_words;
  kblc_pkg::job_t              job;

  assign ev_take  = ev_valid_q && job_free;
  assign in_i.ready = !ev_valid_q || ev_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      ev_valid_q <= 1'b1;
    end else if (ev_take) begin
      ev_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      ev_op_q    <= in_i.op;
      ev_value_q <= in_i.value;
    end
  end

  kblc_state u_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (ev_take),
    .op_i        (ev_op_q),
    .value_i     (ev_value_q),
    .job_o       (job),
    .has_words_o (has_words)
  );

  kblc_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (ev_take && has_words),
    .job_i      (job),
    .job_free_o (job_free),
    .out_o      (out_o)
  );

endmodule
